@@ sv/sst_pkg.sv @@
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types and constants of the streaming source tokenizer: token kinds,
// keyword text, and the record that travels from the scanner to the queue.
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int KW_COUNT = 17;

    localparam logic [5:0] K_IDENT  = 6'd17;
    localparam logic [5:0] K_STRING = 6'd18;
    localparam logic [5:0] K_NUMBER = 6'd19;
    localparam logic [5:0] K_EQ     = 6'd20;
    localparam logic [5:0] K_NE     = 6'd21;
    localparam logic [5:0] K_LT     = 6'd22;
    localparam logic [5:0] K_GT     = 6'd23;
    localparam logic [5:0] K_LE     = 6'd24;
    localparam logic [5:0] K_GE     = 6'd25;
    localparam logic [5:0] K_PLUS   = 6'd26;
    localparam logic [5:0] K_MINUS  = 6'd27;
    localparam logic [5:0] K_STAR   = 6'd28;
    localparam logic [5:0] K_DIV    = 6'd29;
    localparam logic [5:0] K_MOD    = 6'd30;
    localparam logic [5:0] K_CARET  = 6'd31;
    localparam logic [5:0] K_ASSIGN = 6'd32;
    localparam logic [5:0] K_NOT    = 6'd13;
    localparam logic [5:0] K_LBRACE = 6'd33;
    localparam logic [5:0] K_RBRACE = 6'd34;
    localparam logic [5:0] K_LPAREN = 6'd35;
    localparam logic [5:0] K_RPAREN = 6'd36;
    localparam logic [5:0] K_LBRACK = 6'd37;
    localparam logic [5:0] K_RBRACK = 6'd38;
    localparam logic [5:0] K_COMMA  = 6'd39;
    localparam logic [5:0] K_SEMI   = 6'd40;
    localparam logic [5:0] K_COLON  = 6'd41;
    localparam logic [5:0] K_DOT    = 6'd42;
    localparam logic [5:0] K_VARREF = 6'd43;
    localparam logic [5:0] K_TMPL   = 6'd44;
    localparam logic [5:0] K_EOF    = 6'd45;
    localparam logic [5:0] K_ERROR  = 6'd46;

    // Keyword text is right-justified: the first character is the highest byte.
    localparam logic [79:0] KW_STR [KW_COUNT] = '{
        "PROMPT", "VAR", "TEMPLATE", "CONSTRAINT", "OUTPUT", "IF", "ELSE",
        "FOR", "WHILE", "IN", "AS", "AND", "OR", "NOT", "RAW", "true", "false"
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd6, 4'd3, 4'd8, 4'd10, 4'd6, 4'd2, 4'd4, 4'd3, 4'd5,
        4'd2, 4'd2, 4'd3, 4'd2, 4'd3, 4'd3, 4'd4, 4'd5
    };

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] line;
        logic [15:0] column;
        logic [15:0] length;
        logic        run_end;
    } tok_t;

    typedef struct packed {
        logic [1:0]       cnt;
        tok_t [2:0]       tok;
    } tok_burst_t;

    function automatic logic [7:0] kw_char(input logic [4:0] k, input logic [3:0] i);
        logic [79:0] s;
        logic [3:0]  pos;
        s   = KW_STR[k];
        pos = KW_LEN[k] - 4'd1 - i;
        return s[{pos, 3'b000} +: 8];
    endfunction

endpackage

@@ sv/streaming_source_tokenizer.sv @@
// ----------------------------------------------------------------------------
// streaming_source_tokenizer
// Byte-stream lexer that turns source text into token records.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one source byte per item (character, final_byte),
// with in_valid and in_stall. The output channel gives token records
// (token_kind, token_line, token_column, token_length, run_end) with
// out_valid and out_stall; run_end marks the last record caused by a byte.
// A byte is scanned in the cycle it is accepted, and its records are written
// into an eight-entry result queue, so the first one shows on the output in
// the next cycle. One byte is accepted every cycle while the queue has room
// for three more records; one record leaves per cycle when not stalled, so
// bytes causing two or three records slow the input to the output's pace.
// When the receiver stalls, the queue fills and in_stall rises once fewer
// than three entries are free; the head record holds steady meanwhile.
// Reset empties the queue and returns the scanner to line 1, column 1,
// between tokens. The last byte of a text also returns the scanner to that
// state after its records are produced.
// ----------------------------------------------------------------------------
module streaming_source_tokenizer #(
    parameter int COUNTER_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  character,
    input  logic        final_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  token_kind,
    output logic [15:0] token_line,
    output logic [15:0] token_column,
    output logic [15:0] token_length,
    output logic        run_end
);

    sst_pkg::tok_burst_t burst;
    sst_pkg::tok_t       queue [8];
    logic [2:0]          wr_ptr_reg, rd_ptr_reg;
    logic [3:0]          count_reg;
    logic                step, pop;

    assign in_stall  = (count_reg > 4'd5);
    assign step      = in_valid && !in_stall;
    assign out_valid = (count_reg != 4'd0);
    assign pop       = out_valid && !out_stall;

    sst_core #(
        .COUNTER_BITS(COUNTER_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .character  (character),
        .final_byte (final_byte),
        .burst      (burst)
    );

    always_ff @(posedge clk)
    begin
        if (step) begin
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < burst.cnt) queue[wr_ptr_reg + 3'(i)] <= burst.tok[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (step) wr_ptr_reg <= wr_ptr_reg + 3'(burst.cnt);
            if (pop) rd_ptr_reg <= rd_ptr_reg + 3'd1;
            count_reg <= count_reg + (step ? 4'(burst.cnt) : 4'd0) - (pop ? 4'd1 : 4'd0);
        end
    end

    assign token_kind   = queue[rd_ptr_reg].kind;
    assign token_line   = queue[rd_ptr_reg].line;
    assign token_column = queue[rd_ptr_reg].column;
    assign token_length = queue[rd_ptr_reg].length;
    assign run_end      = queue[rd_ptr_reg].run_end;

endmodule

@@ sv/sst_core.sv @@
// ----------------------------------------------------------------------------
// sst_core
// Scanner state and the single-pass step logic: one byte in, up to three
// token records out, all decided in the cycle the byte is accepted.
// ----------------------------------------------------------------------------
module sst_core #(
    parameter int COUNTER_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          character,
    input  logic                final_byte,
    output sst_pkg::tok_burst_t burst
);

    localparam int CB = COUNTER_BITS;

    typedef enum logic [3:0] {
        M_IDLE, M_SLASH, M_LINE, M_BLOCK, M_BSTAR, M_OPER, M_REF,
        M_IDENT, M_NINT, M_NFRAC, M_STR, M_ESC
    } mode_t;

    mode_t              mode_reg, mode_next;
    logic [7:0]         pend_reg, pend_next;
    logic [CB-1:0]      cur_line_reg, cur_line_next;
    logic [CB-1:0]      cur_col_reg, cur_col_next;
    logic [CB-1:0]      start_line_reg, start_line_next;
    logic [CB-1:0]      start_col_reg, start_col_next;
    logic [CB-1:0]      lex_cnt_reg, lex_cnt_next;
    logic [16:0]        kw_cand_reg, kw_cand_next;
    logic               quote_reg, quote_next;
    logic               halt_reg, halt_next;

    function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
        return (v == {CB{1'b1}}) ? v : v + CB'(1);
    endfunction

    function automatic logic [15:0] clamp16(input logic [CB-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic sst_pkg::tok_t mk(input logic [5:0] kind, input logic [CB-1:0] line,
                                         input logic [CB-1:0] col, input logic [CB-1:0] len);
        sst_pkg::tok_t t;
        t.kind    = kind;
        t.line    = clamp16(line);
        t.column  = clamp16(col);
        t.length  = clamp16(len);
        t.run_end = 1'b0;
        return t;
    endfunction

    function automatic logic [5:0] ident_kind(input logic [16:0] kc, input logic [CB-1:0] lc,
                                              input logic [7:0] pend);
        logic [5:0] kind;
        kind = sst_pkg::K_IDENT;
        if (pend == "$") kind = sst_pkg::K_VARREF;
        else if (pend == "@") kind = sst_pkg::K_TMPL;
        else begin
            // Walk downward so the lowest matching keyword wins.
            for (int k = sst_pkg::KW_COUNT - 1; k >= 0; k--) begin
                if (kc[k] && lc == CB'(sst_pkg::KW_LEN[k])) kind = 6'(k);
            end
        end
        return kind;
    endfunction

    function automatic logic [5:0] single_op(input logic [7:0] p);
        logic [5:0] kind;
        unique case (p)
            "=":     kind = sst_pkg::K_ASSIGN;
            "!":     kind = sst_pkg::K_NOT;
            "<":     kind = sst_pkg::K_LT;
            default: kind = sst_pkg::K_GT;
        endcase
        return kind;
    endfunction

    function automatic logic [5:0] double_op(input logic [7:0] p);
        logic [5:0] kind;
        unique case (p)
            "=":     kind = sst_pkg::K_EQ;
            "!":     kind = sst_pkg::K_NE;
            "<":     kind = sst_pkg::K_LE;
            default: kind = sst_pkg::K_GE;
        endcase
        return kind;
    endfunction

    logic is_digit, is_idstart, is_idchar;
    assign is_digit   = (character >= "0") && (character <= "9");
    assign is_idstart = ((character >= "A") && (character <= "Z")) ||
                        ((character >= "a") && (character <= "z")) || (character == "_");
    assign is_idchar  = is_idstart || is_digit;

    always_comb
    begin
        logic [2:0]         n;
        sst_pkg::tok_t [2:0] res;
        logic               do_idle;
        logic               do_ichar;
        logic [5:0]         pk;

        mode_next       = mode_reg;
        pend_next       = pend_reg;
        start_line_next = start_line_reg;
        start_col_next  = start_col_reg;
        lex_cnt_next    = lex_cnt_reg;
        kw_cand_next    = kw_cand_reg;
        quote_next      = quote_reg;
        halt_next       = halt_reg;
        n        = 3'd0;
        res      = '0;
        do_idle  = 1'b0;
        do_ichar = 1'b0;
        pk       = '0;

        if (!halt_reg) begin
            unique case (mode_reg)
                M_SLASH:
                begin
                    if (character == "/") mode_next = M_LINE;
                    else if (character == "*") mode_next = M_BLOCK;
                    else begin
                        res[n[1:0]] = mk(sst_pkg::K_DIV, start_line_reg, start_col_reg, CB'(1));
                        n = n + 3'd1;
                        do_idle = 1'b1;
                    end
                end
                M_LINE:
                begin
                    if (character == 8'h0A) mode_next = M_IDLE;
                end
                M_BLOCK:
                begin
                    if (character == "*") mode_next = M_BSTAR;
                end
                M_BSTAR:
                begin
                    if (character == "/") mode_next = M_IDLE;
                    else if (character != "*") mode_next = M_BLOCK;
                end
                M_OPER:
                begin
                    if (character == "=") begin
                        mode_next = M_IDLE;
                        res[n[1:0]] = mk(double_op(pend_reg), start_line_reg, start_col_reg,
                                         CB'(2));
                        n = n + 3'd1;
                        pend_next = '0;
                    end else begin
                        res[n[1:0]] = mk(single_op(pend_reg), start_line_reg, start_col_reg,
                                         CB'(1));
                        n = n + 3'd1;
                        pend_next = '0;
                        do_idle = 1'b1;
                    end
                end
                M_REF:
                begin
                    if (is_idstart) begin
                        mode_next       = M_IDENT;
                        start_line_next = cur_line_reg;
                        start_col_next  = cur_col_reg;
                        lex_cnt_next    = '0;
                        kw_cand_next    = '1;
                        do_ichar        = 1'b1;
                    end else begin
                        res[n[1:0]] = mk(sst_pkg::K_ERROR, cur_line_reg, cur_col_reg, CB'(1));
                        n = n + 3'd1;
                        halt_next = 1'b1;
                        mode_next = M_IDLE;
                    end
                end
                M_IDENT:
                begin
                    if (is_idchar) do_ichar = 1'b1;
                    else begin
                        res[n[1:0]] = mk(ident_kind(kw_cand_reg, lex_cnt_reg, pend_reg),
                                         start_line_reg, start_col_reg, lex_cnt_reg);
                        n = n + 3'd1;
                        pend_next = '0;
                        do_idle = 1'b1;
                    end
                end
                M_NINT, M_NFRAC:
                begin
                    if (is_digit) lex_cnt_next = sat_inc(lex_cnt_reg);
                    else if (character == "." && mode_reg == M_NINT) begin
                        mode_next    = M_NFRAC;
                        lex_cnt_next = sat_inc(lex_cnt_reg);
                    end else begin
                        res[n[1:0]] = mk(sst_pkg::K_NUMBER, start_line_reg, start_col_reg,
                                         lex_cnt_reg);
                        n = n + 3'd1;
                        do_idle = 1'b1;
                    end
                end
                M_STR:
                begin
                    if (character == "\\") begin
                        mode_next    = M_ESC;
                        lex_cnt_next = sat_inc(lex_cnt_reg);
                    end else if (character == (quote_reg ? 8'h27 : 8'h22)) begin
                        lex_cnt_next = sat_inc(lex_cnt_reg);
                        mode_next    = M_IDLE;
                        res[n[1:0]] = mk(sst_pkg::K_STRING, start_line_reg, start_col_reg,
                                         lex_cnt_next);
                        n = n + 3'd1;
                    end else if (character == 8'h0A) begin
                        res[n[1:0]] = mk(sst_pkg::K_ERROR, cur_line_reg, cur_col_reg, CB'(1));
                        n = n + 3'd1;
                        halt_next = 1'b1;
                        mode_next = M_IDLE;
                    end else begin
                        lex_cnt_next = sat_inc(lex_cnt_reg);
                    end
                end
                M_ESC:
                begin
                    lex_cnt_next = sat_inc(lex_cnt_reg);
                    mode_next    = M_STR;
                end
                default:
                begin
                    do_idle = 1'b1;
                end
            endcase
        end

        // Handling of a byte seen between tokens.
        if (do_idle) begin
            mode_next = M_IDLE;
            pk = '0;
            unique case (character)
                "+": pk = sst_pkg::K_PLUS;
                "-": pk = sst_pkg::K_MINUS;
                "*": pk = sst_pkg::K_STAR;
                "%": pk = sst_pkg::K_MOD;
                "^": pk = sst_pkg::K_CARET;
                "{": pk = sst_pkg::K_LBRACE;
                "}": pk = sst_pkg::K_RBRACE;
                "(": pk = sst_pkg::K_LPAREN;
                ")": pk = sst_pkg::K_RPAREN;
                "[": pk = sst_pkg::K_LBRACK;
                "]": pk = sst_pkg::K_RBRACK;
                ",": pk = sst_pkg::K_COMMA;
                ";": pk = sst_pkg::K_SEMI;
                ":": pk = sst_pkg::K_COLON;
                ".": pk = sst_pkg::K_DOT;
                default: pk = '0;
            endcase
            if (pk != '0) begin
                res[n[1:0]] = mk(pk, cur_line_reg, cur_col_reg, CB'(1));
                n = n + 3'd1;
            end else if (character == "/") begin
                mode_next       = M_SLASH;
                start_line_next = cur_line_reg;
                start_col_next  = cur_col_reg;
            end else if (character == "=" || character == "!" || character == "<" ||
                         character == ">") begin
                mode_next       = M_OPER;
                pend_next       = character;
                start_line_next = cur_line_reg;
                start_col_next  = cur_col_reg;
            end else if (character == "$" || character == "@") begin
                mode_next = M_REF;
                pend_next = character;
            end else if (character == 8'h22 || character == 8'h27) begin
                mode_next       = M_STR;
                quote_next      = (character == 8'h27);
                start_line_next = cur_line_reg;
                start_col_next  = cur_col_reg;
                lex_cnt_next    = CB'(1);
            end else if (is_digit) begin
                mode_next       = M_NINT;
                start_line_next = cur_line_reg;
                start_col_next  = cur_col_reg;
                lex_cnt_next    = CB'(1);
            end else if (is_idstart) begin
                mode_next       = M_IDENT;
                pend_next       = '0;
                start_line_next = cur_line_reg;
                start_col_next  = cur_col_reg;
                lex_cnt_next    = '0;
                kw_cand_next    = '1;
                do_ichar        = 1'b1;
            end
        end

        // One identifier character: prune keywords that no longer match.
        if (do_ichar) begin
            for (int k = 0; k < sst_pkg::KW_COUNT; k++) begin
                if (!(lex_cnt_next < CB'(sst_pkg::KW_LEN[k]) &&
                      sst_pkg::kw_char(5'(k), lex_cnt_next[3:0]) == character))
                    kw_cand_next[k] = 1'b0;
            end
            lex_cnt_next = sat_inc(lex_cnt_next);
        end

        if (character == 8'h0A) begin
            cur_line_next = sat_inc(cur_line_reg);
            cur_col_next  = CB'(1);
        end else begin
            cur_line_next = cur_line_reg;
            cur_col_next  = sat_inc(cur_col_reg);
        end

        if (final_byte) begin
            if (!halt_next) begin
                unique case (mode_next)
                    M_IDENT:
                    begin
                        res[n[1:0]] = mk(ident_kind(kw_cand_next, lex_cnt_next, pend_next),
                                         start_line_next, start_col_next, lex_cnt_next);
                        n = n + 3'd1;
                    end
                    M_NINT, M_NFRAC:
                    begin
                        res[n[1:0]] = mk(sst_pkg::K_NUMBER, start_line_next, start_col_next,
                                         lex_cnt_next);
                        n = n + 3'd1;
                    end
                    M_SLASH:
                    begin
                        res[n[1:0]] = mk(sst_pkg::K_DIV, start_line_next, start_col_next,
                                         CB'(1));
                        n = n + 3'd1;
                    end
                    M_OPER:
                    begin
                        res[n[1:0]] = mk(single_op(pend_next), start_line_next,
                                         start_col_next, CB'(1));
                        n = n + 3'd1;
                    end
                    M_REF, M_STR, M_ESC:
                    begin
                        res[n[1:0]] = mk(sst_pkg::K_ERROR, cur_line_next, cur_col_next, '0);
                        n = n + 3'd1;
                        halt_next = 1'b1;
                    end
                    default: ;
                endcase
                if (!halt_next) begin
                    res[n[1:0]] = mk(sst_pkg::K_EOF, cur_line_next, cur_col_next, '0);
                    n = n + 3'd1;
                end
            end
            mode_next       = M_IDLE;
            pend_next       = '0;
            cur_line_next   = CB'(1);
            cur_col_next    = CB'(1);
            start_line_next = CB'(1);
            start_col_next  = CB'(1);
            lex_cnt_next    = '0;
            kw_cand_next    = '1;
            quote_next      = 1'b0;
            halt_next       = 1'b0;
        end

        if (n != 3'd0) res[n[1:0] - 2'd1].run_end = 1'b1;
        burst.cnt = n[1:0];
        burst.tok = res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg       <= M_IDLE;
            pend_reg       <= '0;
            cur_line_reg   <= CB'(1);
            cur_col_reg    <= CB'(1);
            start_line_reg <= CB'(1);
            start_col_reg  <= CB'(1);
            lex_cnt_reg    <= '0;
            kw_cand_reg    <= '1;
            quote_reg      <= 1'b0;
            halt_reg       <= 1'b0;
        end else if (step) begin
            mode_reg       <= mode_next;
            pend_reg       <= pend_next;
            cur_line_reg   <= cur_line_next;
            cur_col_reg    <= cur_col_next;
            start_line_reg <= start_line_next;
            start_col_reg  <= start_col_next;
            lex_cnt_reg    <= lex_cnt_next;
            kw_cand_reg    <= kw_cand_next;
            quote_reg      <= quote_next;
            halt_reg       <= halt_next;
        end
    end

endmodule

@@ sv/sst_checker.sv @@
// ----------------------------------------------------------------------------
// sst_checker
// Port-level checks of the tokenizer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module sst_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [5:0]  token_kind,
    input logic        run_end
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> token_kind <= sst_pkg::K_ERROR)
        else $error("token kind out of range");

    // Nothing follows end of text or an error within the same byte.
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == sst_pkg::K_EOF |-> run_end)
        else $error("EOF is not the last record of its byte");

    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == sst_pkg::K_ERROR |-> run_end)
        else $error("ERROR is not the last record of its byte");

endmodule

bind streaming_source_tokenizer sst_checker u_sst_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .token_kind (token_kind),
    .run_end    (run_end)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives source text into the tokenizer one byte per item and checks every
// token record against a behavioral scanner kept in the testbench, under
// several phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module tb_top;

    typedef enum int {
        S_IDLE, S_SLASH, S_LINE, S_BLOCK, S_BSTAR, S_OPER, S_REF,
        S_IDENT, S_NINT, S_NFRAC, S_STR, S_ESC
    } scan_e;

    class token_scoreboard;
        sst_pkg::tok_t expected_q[$];
        int    errors;
        scan_e mode;
        byte unsigned op_char;
        int    line_no, col_no, tok_line, tok_col, lex_len;
        logic [sst_pkg::KW_COUNT-1:0] kw_live;
        bit    single_quote, halted;
        sst_pkg::tok_t burst[$];

        function new();
            errors = 0;
            clear_state();
        endfunction

        function void clear_state();
            mode = S_IDLE; op_char = 0; line_no = 1; col_no = 1;
            tok_line = 1; tok_col = 1; lex_len = 0; kw_live = '1;
            single_quote = 0; halted = 0;
        endfunction

        function int bump(int v);
            return (v < 65535) ? v + 1 : v;
        endfunction

        function void push_token(logic [5:0] k, int ln, int cl, int len);
            sst_pkg::tok_t t;
            if (burst.size() >= 3) return;
            t.kind = k; t.line = ln[15:0]; t.column = cl[15:0];
            t.length = len[15:0]; t.run_end = 0;
            burst.push_back(t);
        endfunction

        function void mark();
            tok_line = line_no; tok_col = col_no;
        endfunction

        function bit id_start(byte unsigned c);
            return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
        endfunction

        function bit is_num(byte unsigned c);
            return c >= "0" && c <= "9";
        endfunction

        function void fail_here(int len);
            push_token(sst_pkg::K_ERROR, line_no, col_no, len);
            halted = 1; mode = S_IDLE;
        endfunction

        function void add_id_char(byte unsigned c);
            logic [79:0] s;
            for (int k = 0; k < sst_pkg::KW_COUNT; k++) begin
                s = sst_pkg::KW_STR[k];
                if (!(lex_len < sst_pkg::KW_LEN[k] &&
                      s[(sst_pkg::KW_LEN[k] - 1 - lex_len) * 8 +: 8] == c))
                    kw_live[k] = 0;
            end
            lex_len = bump(lex_len);
        endfunction

        function void open_ident(byte unsigned c, byte unsigned ref_ch);
            mode = S_IDENT; op_char = ref_ch; mark(); lex_len = 0; kw_live = '1;
            add_id_char(c);
        endfunction

        function void close_ident();
            logic [5:0] k;
            k = sst_pkg::K_IDENT;
            if (op_char == "$") k = sst_pkg::K_VARREF;
            else if (op_char == "@") k = sst_pkg::K_TMPL;
            else
                for (int i = sst_pkg::KW_COUNT - 1; i >= 0; i--)
                    if (kw_live[i] && sst_pkg::KW_LEN[i] == lex_len) k = i[5:0];
            mode = S_IDLE; op_char = 0;
            push_token(k, tok_line, tok_col, lex_len);
        endfunction

        function logic [5:0] op_kind(byte unsigned c, bit dbl);
            case (c)
                "=": return dbl ? sst_pkg::K_EQ : sst_pkg::K_ASSIGN;
                "!": return dbl ? sst_pkg::K_NE : sst_pkg::K_NOT;
                "<": return dbl ? sst_pkg::K_LE : sst_pkg::K_LT;
                default: return dbl ? sst_pkg::K_GE : sst_pkg::K_GT;
            endcase
        endfunction

        function void close_oper();
            mode = S_IDLE;
            push_token(op_kind(op_char, 0), tok_line, tok_col, 1);
            op_char = 0;
        endfunction

        function void scan_idle(byte unsigned c);
            logic [5:0] k;
            case (c)
                " ", "\t", 8'h0D, "\n": return;
                "/": begin mode = S_SLASH; mark(); return; end
                "=", "!", "<", ">": begin mode = S_OPER; op_char = c; mark(); return; end
                "$", "@": begin mode = S_REF; op_char = c; return; end
                "\"", "'": begin
                    mode = S_STR; single_quote = (c == "'"); mark(); lex_len = 1; return;
                end
                "+": k = sst_pkg::K_PLUS;
                "-": k = sst_pkg::K_MINUS;
                "*": k = sst_pkg::K_STAR;
                "%": k = sst_pkg::K_MOD;
                "^": k = sst_pkg::K_CARET;
                "{": k = sst_pkg::K_LBRACE;
                "}": k = sst_pkg::K_RBRACE;
                "(": k = sst_pkg::K_LPAREN;
                ")": k = sst_pkg::K_RPAREN;
                "[": k = sst_pkg::K_LBRACK;
                "]": k = sst_pkg::K_RBRACK;
                ",": k = sst_pkg::K_COMMA;
                ";": k = sst_pkg::K_SEMI;
                ":": k = sst_pkg::K_COLON;
                ".": k = sst_pkg::K_DOT;
                default: begin
                    if (is_num(c)) begin mode = S_NINT; mark(); lex_len = 1; end
                    else if (id_start(c)) open_ident(c, 0);
                    return;
                end
            endcase
            push_token(k, line_no, col_no, 1);
        endfunction

        // Works out the token records that one accepted byte causes.
        function void note_byte(byte unsigned c, bit last);
            burst.delete();
            if (!halted) begin
                case (mode)
                    S_SLASH:
                        if (c == "/") mode = S_LINE;
                        else if (c == "*") mode = S_BLOCK;
                        else begin
                            mode = S_IDLE;
                            push_token(sst_pkg::K_DIV, tok_line, tok_col, 1);
                            scan_idle(c);
                        end
                    S_LINE: if (c == "\n") mode = S_IDLE;
                    S_BLOCK: if (c == "*") mode = S_BSTAR;
                    S_BSTAR:
                        if (c == "/") mode = S_IDLE;
                        else if (c != "*") mode = S_BLOCK;
                    S_OPER:
                        if (c == "=") begin
                            mode = S_IDLE;
                            push_token(op_kind(op_char, 1), tok_line, tok_col, 2);
                            op_char = 0;
                        end else begin
                            close_oper();
                            scan_idle(c);
                        end
                    S_REF:
                        if (id_start(c)) open_ident(c, op_char);
                        else fail_here(1);
                    S_IDENT:
                        if (id_start(c) || is_num(c)) add_id_char(c);
                        else begin close_ident(); scan_idle(c); end
                    S_NINT, S_NFRAC:
                        if (is_num(c)) lex_len = bump(lex_len);
                        else if (c == "." && mode == S_NINT) begin
                            mode = S_NFRAC; lex_len = bump(lex_len);
                        end else begin
                            mode = S_IDLE;
                            push_token(sst_pkg::K_NUMBER, tok_line, tok_col, lex_len);
                            scan_idle(c);
                        end
                    S_STR:
                        if (c == "\\") begin mode = S_ESC; lex_len = bump(lex_len); end
                        else if (c == (single_quote ? "'" : "\"")) begin
                            lex_len = bump(lex_len); mode = S_IDLE;
                            push_token(sst_pkg::K_STRING, tok_line, tok_col, lex_len);
                        end else if (c == "\n") fail_here(1);
                        else lex_len = bump(lex_len);
                    S_ESC: begin lex_len = bump(lex_len); mode = S_STR; end
                    default: scan_idle(c);
                endcase
            end
            if (c == "\n") begin line_no = bump(line_no); col_no = 1; end
            else col_no = bump(col_no);
            if (last) begin
                if (!halted) begin
                    case (mode)
                        S_IDENT: close_ident();
                        S_NINT, S_NFRAC:
                            push_token(sst_pkg::K_NUMBER, tok_line, tok_col, lex_len);
                        S_SLASH: push_token(sst_pkg::K_DIV, tok_line, tok_col, 1);
                        S_OPER: close_oper();
                        S_REF, S_STR, S_ESC: fail_here(0);
                        default: ;
                    endcase
                    if (!halted) push_token(sst_pkg::K_EOF, line_no, col_no, 0);
                end
                clear_state();
            end
            if (burst.size() > 0) burst[burst.size() - 1].run_end = 1;
            foreach (burst[i]) expected_q.push_back(burst[i]);
        endfunction

        function void check_token(sst_pkg::tok_t got);
            sst_pkg::tok_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected token, expected none, actual %p", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.kind !== want.kind) begin
                $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
                errors++;
            end
            if (got.line !== want.line) begin
                $display("%0t: line expected %0d actual %0d", $time, want.line, got.line);
                errors++;
            end
            if (got.column !== want.column) begin
                $display("%0t: column expected %0d actual %0d", $time, want.column,
                         got.column);
                errors++;
            end
            if (got.length !== want.length) begin
                $display("%0t: length expected %0d actual %0d", $time, want.length,
                         got.length);
                errors++;
            end
            if (got.run_end !== want.run_end) begin
                $display("%0t: run_end expected %0d actual %0d", $time, want.run_end,
                         got.run_end);
                errors++;
            end
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 5000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [7:0]  character = 0;
    logic        final_byte = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [5:0]  token_kind;
    logic [15:0] token_line, token_column, token_length;
    logic        run_end;

    token_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  quiet_cycles = 0;
    byte unsigned text_q[$];

    streaming_source_tokenizer dut (.*);

    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    always @(posedge clk)
    begin
        sst_pkg::tok_t t;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                t.kind = token_kind; t.line = token_line; t.column = token_column;
                t.length = token_length; t.run_end = run_end;
                sb.check_token(t);
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Sends one byte and waits for it to be taken; valid stays high after.
    task automatic send_byte(byte unsigned c, bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        character <= c;
        final_byte <= last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_byte(c, last);
    endtask

    // Sends the collected text, with the last byte marked when asked.
    task automatic send_text(bit close_it);
        for (int i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], close_it && i == text_q.size() - 1);
        text_q.delete();
    endtask

    task automatic add_str(string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endtask

    function automatic string pick_word();
        string words[$] = '{"PROMPT", "VAR", "TEMPLATE", "CONSTRAINT", "OUTPUT", "IF",
                           "ELSE", "FOR", "WHILE", "IN", "AS", "AND", "OR", "NOT",
                           "RAW", "true", "false", "x", "_a9", "PROMPTS", "Tru", "ELS"};
        return words[$urandom_range(words.size() - 1)];
    endfunction

    // Adds one random lexeme, mostly well formed, sometimes broken or noise.
    task automatic add_lexeme();
        string ops = "+-*%^{}()[],;:.=!<>/";
        int sel;
        sel = $urandom_range(15);
        case (sel)
            0, 1, 2: add_str(pick_word());
            3: begin add_str("$"); add_str(pick_word()); end
            4: begin add_str("@"); add_str(pick_word()); end
            5: begin
                add_str($sformatf("%0d", $urandom_range(9999)));
                if ($urandom_range(1)) add_str($sformatf(".%0d", $urandom_range(99)));
            end
            6: add_str("\"a\\\"b c\"");
            7: add_str("'x\\\ny'");
            8: text_q.push_back(ops[$urandom_range(ops.len() - 1)]);
            9: begin
                text_q.push_back(ops[15 + $urandom_range(3)]);
                if ($urandom_range(1)) add_str("=");
            end
            10: add_str("// note\n");
            11: add_str("/* a * b **/");
            12: text_q.push_back(8'($urandom_range(255)));
            13: add_str("$1");
            14: add_str("\"open\nx");
            default: add_str("\n");
        endcase
        if ($urandom_range(2) == 0) add_str($urandom_range(1) ? " " : "\t");
    endtask

    task automatic drain_out();
        in_valid <= 0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int sent;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: keywords, operators, references, strings, numbers, errors.
        add_str("PROMPT VAR TEMPLATE CONSTRAINT OUTPUT IF ELSE FOR WHILE IN AS\n");
        add_str("AND OR NOT RAW true false foo_1 ");
        send_text(1);
        add_str("== != <= >= < > = ! + - * / % ^ {}()[],;:. 12 3.5 7. .4");
        send_text(1);
        add_str("$v @t /* x */ // c\n\"s\\\"q\" 'a\\\nb' x/");
        send_text(1);
        add_str("$ z"); send_text(1);
        add_str("\"ab\ncd"); send_text(1);
        add_str("'open"); send_text(1);
        add_str("@"); send_text(1);
        add_str("a"); text_q.push_back(8'h00); text_q.push_back(8'hFF);
        text_q.push_back(8'h80); add_str("/* open"); send_text(1);
        add_str("<"); send_text(1);
        add_str("x"); send_text(1);
        drain_out();

        // Random phases: none, sender idle, receiver stall, both.
        sent = 0;
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 65 : (ph == 3) ? 24 : 0;
            recv_stall_pct = (ph == 2) ? 65 : (ph == 3) ? 24 : 0;
            while (sent < (ph + 1) * 40) begin
                while (text_q.size() < 25) add_lexeme();
                sent += text_q.size();
                send_text($urandom_range(3) == 0);
            end
            add_str(";"); sent++;
            send_text(1);
            if (ph == 1) drain_out();
        end
        recv_stall_pct = 0;

        drain_out();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
